### hw/rtl/dmcr_pkg.sv
// Shared types, codes, font tables and helper functions for the digit matrix column renderer.
package dmcr_pkg;

  localparam int unsigned MATRIX_COUNT_DEF = 4;
  localparam int unsigned CELL_COUNT       = 6;

  localparam logic [1:0] CMD_WRITE  = 2'd0;
  localparam logic [1:0] CMD_BLANK  = 2'd1;
  localparam logic [1:0] CMD_REDRAW = 2'd2;

  localparam logic [3:0] CELL_BLANK      = 4'd15;
  localparam logic [3:0] CELL_DIGIT_LIM  = 4'd10;
  localparam logic [2:0] LAST_POS        = 3'd5;
  localparam logic [2:0] LAST_WIDE_POS   = 3'd3;
  localparam logic [2:0] WIDE_LAST_COL   = 3'd4;
  localparam logic [2:0] NARROW_LAST_COL = 3'd2;

  // floor(x/10) = (x * DIV10_RECIP) >> 23, exact for 20-bit x
  localparam logic [19:0] DIV10_RECIP = 20'd838861;

  localparam logic [7:0] WIDE_FONT [50] = '{
    8'h7E, 8'hFF, 8'h81, 8'hFF, 8'h7E,
    8'h00, 8'h04, 8'hFE, 8'hFF, 8'h00,
    8'hC2, 8'hE1, 8'hB1, 8'h9F, 8'h8E,
    8'h49, 8'h8D, 8'h8F, 8'hFB, 8'h71,
    8'h38, 8'h24, 8'hFE, 8'hFF, 8'h20,
    8'h4F, 8'h8F, 8'h89, 8'hF9, 8'h71,
    8'h7E, 8'hFF, 8'h89, 8'hF9, 8'h70,
    8'h01, 8'hF1, 8'hF9, 8'h0F, 8'h07,
    8'h76, 8'hFF, 8'h89, 8'hFF, 8'h76,
    8'h0E, 8'h9F, 8'h91, 8'hFF, 8'h7E
  };

  localparam logic [7:0] NARROW_FONT [30] = '{
    8'hF8, 8'h88, 8'hF8,
    8'h10, 8'hF8, 8'h00,
    8'hE8, 8'hA8, 8'hB8,
    8'h88, 8'hA8, 8'hF8,
    8'h70, 8'h40, 8'hF8,
    8'hB8, 8'hA8, 8'hE8,
    8'hF8, 8'hA8, 8'hE8,
    8'h08, 8'h08, 8'hF8,
    8'hF8, 8'hA8, 8'hF8,
    8'hB8, 8'hA8, 8'hF8
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_DIGITS,
    ST_SETUP,
    ST_RENDER
  } state_t;

  typedef struct packed {
    logic load;
    logic digit_step;
    logic blank;
    logic render_init;
    logic render_step;
  } ctrl_cmd_t;

  typedef struct packed {
    logic range_ok;
    logic cmd_write;
    logic cmd_blank;
    logic digit_last;
    logic render_none;
    logic render_final;
    logic out_free;
  } dp_status_t;

  function automatic logic [4:0] pos_start(input logic [2:0] pos);
    logic [4:0] col;
    case (pos)
      3'd0:    col = 5'd0;
      3'd1:    col = 5'd6;
      3'd2:    col = 5'd13;
      3'd3:    col = 5'd19;
      3'd4:    col = 5'd25;
      default: col = 5'd29;
    endcase
    return col;
  endfunction

  function automatic logic [7:0] font_bits(input logic [3:0] cell_code, input logic narrow,
                                           input logic [2:0] col);
    logic [5:0] idx;
    logic [7:0] bits;
    bits = 8'd0;
    idx  = 6'd0;
    if (cell_code < CELL_DIGIT_LIM) begin
      if (narrow) begin
        idx  = 6'(cell_code) * 6'd3 + 6'(col);
        bits = NARROW_FONT[idx[4:0]];
      end else begin
        idx  = 6'(cell_code) * 6'd5 + 6'(col);
        bits = WIDE_FONT[idx];
      end
    end
    return bits;
  endfunction

endpackage

### hw/rtl/dmcr_ctrl.sv
// Command sequencer: decodes a word, steps digit extraction, then steps column rendering.
module dmcr_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  dmcr_pkg::dp_status_t  status,
  output dmcr_pkg::ctrl_cmd_t   cmd
);

  dmcr_pkg::state_t state_r;
  dmcr_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dmcr_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      dmcr_pkg::ST_IDLE: begin
        if (in_tvalid) state_nxt = dmcr_pkg::ST_DECODE;
      end
      dmcr_pkg::ST_DECODE: begin
        if (!status.range_ok) state_nxt = dmcr_pkg::ST_IDLE;
        else if (status.cmd_write) state_nxt = dmcr_pkg::ST_DIGITS;
        else state_nxt = dmcr_pkg::ST_SETUP;
      end
      dmcr_pkg::ST_DIGITS: begin
        if (status.digit_last) state_nxt = dmcr_pkg::ST_SETUP;
      end
      dmcr_pkg::ST_SETUP: begin
        if (status.render_none) state_nxt = dmcr_pkg::ST_IDLE;
        else state_nxt = dmcr_pkg::ST_RENDER;
      end
      dmcr_pkg::ST_RENDER: begin
        if (status.out_free && status.render_final) state_nxt = dmcr_pkg::ST_IDLE;
      end
      default: state_nxt = dmcr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      dmcr_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      dmcr_pkg::ST_DECODE: begin
        cmd.blank = status.range_ok && status.cmd_blank;
      end
      dmcr_pkg::ST_DIGITS: begin
        cmd.digit_step = 1'b1;
      end
      dmcr_pkg::ST_SETUP: begin
        cmd.render_init = 1'b1;
      end
      dmcr_pkg::ST_RENDER: begin
        cmd.render_step = status.out_free;
      end
      default: cmd = '0;
    endcase
  end

endmodule

### hw/rtl/dmcr_datapath.sv
// Digit cells, decimal digit extraction, column walk and output register.
module dmcr_datapath #(
  parameter int unsigned MATRIX_COUNT = dmcr_pkg::MATRIX_COUNT_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [1:0]            in_cmd,
  input  logic [19:0]           in_number_value,
  input  logic [2:0]            in_first_pos,
  input  logic [2:0]            in_last_pos,
  input  logic                  in_zero_fill,
  input  dmcr_pkg::ctrl_cmd_t   cmd,
  output dmcr_pkg::dp_status_t  status,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [2:0]            out_device_index,
  output logic [2:0]            out_column_index,
  output logic [7:0]            out_column_bits,
  output logic                  out_last_write
);

  localparam logic NARROW_SHOWN = (MATRIX_COUNT > 3);

  logic [3:0]  cells_r [dmcr_pkg::CELL_COUNT];
  logic [3:0]  cells_nxt [dmcr_pkg::CELL_COUNT];
  logic [1:0]  cmd_r;
  logic [2:0]  first_r;
  logic [2:0]  last_r;
  logic        zf_r;
  logic [19:0] q_r;
  logic        place0_r;
  logic [2:0]  pos_r;
  logic [2:0]  col_r;
  logic        out_valid_r;
  logic [2:0]  dev_r;
  logic [2:0]  colidx_r;
  logic [7:0]  bits_r;
  logic        last_out_r;

  logic [39:0] prod;
  logic [19:0] qt;
  logic [19:0] qt10;
  logic [19:0] rem_full;
  logic [3:0]  digit;
  logic        narrow;
  logic        col_end;
  logic        final_col;
  logic [4:0]  logical;
  logic [3:0]  cur_cell;

  assign prod     = 40'(q_r) * 40'(dmcr_pkg::DIV10_RECIP);
  assign qt       = {3'b000, prod[39:23]};
  assign qt10     = (qt << 3) + (qt << 1);
  assign rem_full = q_r - qt10;
  assign digit    = (place0_r || (q_r != 20'd0) || zf_r) ? rem_full[3:0] : dmcr_pkg::CELL_BLANK;

  assign cur_cell  = cells_r[pos_r];
  assign narrow    = pos_r > dmcr_pkg::LAST_WIDE_POS;
  assign col_end   = col_r == (narrow ? dmcr_pkg::NARROW_LAST_COL : dmcr_pkg::WIDE_LAST_COL);
  assign final_col = col_end &&
                     ((pos_r == last_r) || (!NARROW_SHOWN && pos_r == dmcr_pkg::LAST_WIDE_POS));
  assign logical   = dmcr_pkg::pos_start(pos_r) + 5'(col_r);

  always_comb begin
    for (int k = 0; k < dmcr_pkg::CELL_COUNT; k++) begin
      cells_nxt[k] = cells_r[k];
      if (cmd.blank && 3'(k) >= first_r && 3'(k) <= last_r) begin
        cells_nxt[k] = dmcr_pkg::CELL_BLANK;
      end
      if (cmd.digit_step && pos_r == 3'(k)) begin
        cells_nxt[k] = digit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < dmcr_pkg::CELL_COUNT; k++) cells_r[k] <= dmcr_pkg::CELL_BLANK;
      out_valid_r <= 1'b0;
    end else begin
      cells_r <= cells_nxt;
      if (cmd.render_step) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r    <= in_cmd;
      first_r  <= in_first_pos;
      last_r   <= in_last_pos;
      zf_r     <= in_zero_fill;
      q_r      <= in_number_value;
      place0_r <= 1'b1;
      pos_r    <= in_last_pos;
    end else if (cmd.digit_step) begin
      q_r      <= qt;
      place0_r <= 1'b0;
      pos_r    <= pos_r - 3'd1;
    end else if (cmd.render_init) begin
      pos_r <= first_r;
      col_r <= 3'd0;
    end else if (cmd.render_step) begin
      if (col_end) begin
        pos_r <= pos_r + 3'd1;
        col_r <= 3'd0;
      end else begin
        col_r <= col_r + 3'd1;
      end
    end
    if (cmd.render_step) begin
      dev_r      <= {1'b0, logical[4:3]};
      colidx_r   <= ~logical[2:0];
      bits_r     <= dmcr_pkg::font_bits(cur_cell, narrow, col_r);
      last_out_r <= final_col;
    end
  end

  assign status.range_ok     = (cmd_r <= dmcr_pkg::CMD_REDRAW) &&
                               (first_r <= dmcr_pkg::LAST_POS) &&
                               (last_r <= dmcr_pkg::LAST_POS) && (first_r <= last_r);
  assign status.cmd_write    = cmd_r == dmcr_pkg::CMD_WRITE;
  assign status.cmd_blank    = cmd_r == dmcr_pkg::CMD_BLANK;
  assign status.digit_last   = pos_r == first_r;
  assign status.render_none  = !NARROW_SHOWN && (first_r > dmcr_pkg::LAST_WIDE_POS);
  assign status.render_final = final_col;
  assign status.out_free     = !out_valid_r || out_tready;

  assign out_tvalid       = out_valid_r;
  assign out_device_index = dev_r;
  assign out_column_index = colidx_r;
  assign out_column_bits  = bits_r;
  assign out_last_write   = last_out_r;

endmodule

### hw/rtl/digit_matrix_column_renderer_top.sv
// Top level of the digit matrix column renderer: stream ports, sequencer and datapath.
//
// Input stream: one word per command. in_tuser carries the command (write number,
// blank range, redraw range); in_tdata carries value, first and last position and the
// zero-fill flag. Output stream: one word per rendered font column, giving matrix
// index, column within the matrix and the eight LED bits; out_tlast marks the final
// column of a command. Invalid ranges and unknown commands produce no output words.
// Sequence: a command is taken in the idle state and decoded in the decode state; a
// write command then runs one constant-reciprocal divide by ten per digit place in the
// range. A setup state follows, then one column word per cycle while the output is
// free: 5 per wide position, 3 per narrow one. in_tready is high only between
// commands; the next command may be taken while the last column word still waits in
// the output register. Reset (rst_n low, synchronous) blanks all six digit cells and
// empties the output register. When out_tready is low while a word is pending, the
// output word holds and rendering pauses.
module digit_matrix_column_renderer_top #(
  parameter int unsigned MATRIX_COUNT = dmcr_pkg::MATRIX_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // number_value[19:0], first_pos[22:20], last_pos[25:23],
                                  // zero_fill[26], zero pad
  input  logic [1:0]  in_tuser,   // cmd[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // device_index[2:0], column_index[5:3], column_bits[13:6],
                                  // zero pad
  output logic        out_tlast   // last_write
);

  dmcr_pkg::ctrl_cmd_t  cmd;
  dmcr_pkg::dp_status_t status;
  logic [2:0] device_index;
  logic [2:0] column_index;
  logic [7:0] column_bits;

  dmcr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  dmcr_datapath #(
    .MATRIX_COUNT (MATRIX_COUNT)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_cmd           (in_tuser),
    .in_number_value  (in_tdata[19:0]),
    .in_first_pos     (in_tdata[22:20]),
    .in_last_pos      (in_tdata[25:23]),
    .in_zero_fill     (in_tdata[26]),
    .cmd              (cmd),
    .status           (status),
    .out_tvalid       (out_tvalid),
    .out_tready       (out_tready),
    .out_device_index (device_index),
    .out_column_index (column_index),
    .out_column_bits  (column_bits),
    .out_last_write   (out_tlast)
  );

  assign out_tdata = {2'b00, column_bits, column_index, device_index};

endmodule

### hw/rtl/dmcr_checker.sv
// Port-level assertion checker for the digit matrix column renderer, bound to the top level.
module dmcr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        out_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output word changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("new command taken right after accept");

  a_busy_mid_command: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |-> !in_tready)
    else $error("command taken before final column of previous one");

  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[15:14] == 2'b00 && out_tdata[2] == 1'b0)
    else $error("matrix index or padding out of range");

endmodule

bind digit_matrix_column_renderer_top dmcr_checker u_dmcr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
